[rtl/core/kmid_pkg.sv]
// ----------------------------------------------------------------------------
// kmid_pkg
// Shared widths and constants for the key matrix integrator debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package kmid_pkg;

   localparam int KEY_W     = 7;
   localparam int CNT_W     = 7;
   localparam int ENTRY_W   = CNT_W + 1;
   localparam int KEY_SLOTS = 1 << KEY_W;

   localparam logic [CNT_W-1:0] CNT_MAX     = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0] TICKS_RESET = CNT_W'(5);
   localparam logic [CNT_W-1:0] TICKS_MIN   = CNT_W'(1);

   // per-key entry: hysteresis count over the inverted stable level
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             inv_level;
   } entry_type;

endpackage

`default_nettype wire

[rtl/core/kmid_ram.sv]
// ----------------------------------------------------------------------------
// kmid_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kmid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/key_matrix_integrator_debounce_top.sv]
// ----------------------------------------------------------------------------
// key_matrix_integrator_debounce_top
// Per-key integrator debouncer for a scanned key matrix.
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one key sample per word: key index and raw column level.
//   rsp_* carries one word per debounced level change: key index, new level.
//   csr_wr_en / csr_wr_data set the tick count; write it only while idle.
// timing:
//   a sample is registered on acceptance while its key entry is read from
//   the state RAM; the entry is written as the sample retires, loading any
//   event into the rsp_* register. one sample per cycle is sustained unless
//   an event waits on a stalled output, set by the single read-modify-write
//   on the state RAM; back-to-back samples of the same key use the last write.
// reset:
//   every key returns to released with a zero count; per-key valid flags
//   stand in for clearing the RAM, so samples are taken right after reset.
// stall:
//   the output register holds an event until taken; samples that cause
//   no event keep flowing, a sample that causes one waits for a free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_integrator_debounce_top #(
   parameter int ROWS = 8,
   parameter int COLS = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // configuration
   input  wire logic       csr_wr_en,
   input  wire logic [6:0] csr_wr_data,
   // sample stream
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [6:0] key_index, [7] raw_level
   // event stream
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic      [7:0] rsp_tdata    // [6:0] event_key, [7] new_level
);

   localparam int KEYS  = ROWS * COLS;
   localparam int SLOTS = (KEYS < kmid_pkg::KEY_SLOTS) ? KEYS : kmid_pkg::KEY_SLOTS;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [kmid_pkg::KEY_W-1:0] req_key;
   logic                       req_level;
   logic                       req_in_range;
   logic                       accept;

   logic [kmid_pkg::CNT_W-1:0] ticks_ff, ticks_in;

   logic                       s1_valid_ff, s1_valid_in;
   logic [kmid_pkg::KEY_W-1:0] s1_key_ff, s1_key_in;
   logic                       s1_level_ff, s1_level_in;

   logic                       wr_seen_ff, wr_seen_in;
   logic [kmid_pkg::KEY_W-1:0] wr_key_ff, wr_key_in;
   kmid_pkg::entry_type        wr_entry_ff, wr_entry_in;

   logic [SLOTS-1:0]           valid_ff, valid_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [kmid_pkg::KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic                       rsp_level_ff, rsp_level_in;

   logic [kmid_pkg::ENTRY_W-1:0] ram_rd_data;
   kmid_pkg::entry_type          cur_entry;
   kmid_pkg::entry_type          new_entry;
   logic [kmid_pkg::CNT_W-1:0]   eff_ticks;
   logic [kmid_pkg::CNT_W-1:0]   next_count;
   logic                         hit;
   logic                         out_free;
   logic                         s1_done;
   logic                         ram_wr_en;

   assign req_key      = req_tdata[kmid_pkg::KEY_W-1:0];
   assign req_level    = req_tdata[kmid_pkg::KEY_W];
   assign req_in_range = (32'(req_key) < 32'(KEYS));

   // state RAM, one entry per key
   kmid_ram #(
      .WIDTH(kmid_pkg::ENTRY_W),
      .DEPTH(SLOTS)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(s1_key_ff[AW-1:0]),
      .wr_data(new_entry),
      .rd_en  (accept),
      .rd_addr(req_key[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   // entry lookup: last write wins over RAM, never-written reads as released
   always_comb begin
      if (wr_seen_ff && (wr_key_ff == s1_key_ff)) begin
         cur_entry = wr_entry_ff;
      end else if (valid_ff[s1_key_ff[AW-1:0]]) begin
         cur_entry = kmid_pkg::entry_type'(ram_rd_data);
      end else begin
         cur_entry = '0;
      end
   end

   always_comb begin
      eff_ticks = (ticks_ff == '0) ? kmid_pkg::TICKS_MIN : ticks_ff;

      // a sample equal to the inverted stable level disagrees
      if (s1_level_ff == cur_entry.inv_level) begin
         next_count = (cur_entry.count == kmid_pkg::CNT_MAX) ? cur_entry.count
                                                             : cur_entry.count + 1'b1;
      end else begin
         next_count = (cur_entry.count == '0) ? cur_entry.count
                                              : cur_entry.count - 1'b1;
      end

      hit = (next_count >= eff_ticks);

      if (hit) begin
         new_entry.count     = '0;
         new_entry.inv_level = ~s1_level_ff;
      end else begin
         new_entry.count     = next_count;
         new_entry.inv_level = cur_entry.inv_level;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_done    = s1_valid_ff && (!hit || out_free);
   assign ram_wr_en  = s1_done;
   assign req_tready = !s1_valid_ff || s1_done;
   assign accept     = req_tvalid && req_tready && req_in_range;

   always_comb begin
      ticks_in     = csr_wr_en ? csr_wr_data : ticks_ff;

      s1_valid_in  = accept || (s1_valid_ff && !s1_done);
      s1_key_in    = accept ? req_key : s1_key_ff;
      s1_level_in  = accept ? req_level : s1_level_ff;

      wr_seen_in   = wr_seen_ff || s1_done;
      wr_key_in    = s1_done ? s1_key_ff : wr_key_ff;
      wr_entry_in  = s1_done ? new_entry : wr_entry_ff;

      valid_in     = valid_ff;
      if (s1_done) begin
         valid_in[s1_key_ff[AW-1:0]] = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_key_in   = rsp_key_ff;
      rsp_level_in = rsp_level_ff;
      if (s1_done && hit) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = s1_key_ff;
         rsp_level_in = s1_level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff     <= kmid_pkg::TICKS_RESET;
         s1_valid_ff  <= 1'b0;
         wr_seen_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ticks_ff     <= ticks_in;
         s1_valid_ff  <= s1_valid_in;
         wr_seen_ff   <= wr_seen_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_key_ff    <= s1_key_in;
      s1_level_ff  <= s1_level_in;
      wr_key_ff    <= wr_key_in;
      wr_entry_ff  <= wr_entry_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_level_ff, rsp_key_ff};

endmodule

`default_nettype wire

[rtl/core/kmid_checker.sv]
// ----------------------------------------------------------------------------
// kmid_checker
// Port-level checks for the key matrix debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kmid_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [7:0] req_tdata,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   // a waiting event word holds until taken
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("event word dropped or changed while stalled");

   // reset empties the output register
   rsp_reset_a: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("event word present after reset");

   // a fresh event is checked against an accepted sample on req_*
   rsp_cause_a: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("event word without a matching sample");

   // the event carries the key and level of that sample
   rsp_level_a: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> (rsp_tdata == $past(req_tdata, 2)))
      else $error("event word does not match its sample");

endmodule

bind key_matrix_integrator_debounce_top kmid_checker u_kmid_checker (.*);

`default_nettype wire
